>>> design/ghrc_pkg.sv
// Shared types and constants for the grip holding run classifier.
`default_nettype none

package ghrc_pkg;

    // Field widths fixed by the sample and result formats
    localparam int POS_W      = 18;
    localparam int LOAD_W     = 16;
    localparam int PSPREAD_W  = 17;
    localparam int LSPREAD_W  = 15;
    localparam int REQ_W      = 16;
    localparam int OBJ_THR_W  = 21;
    localparam int LOAD_THR_W = 19;
    localparam int OUT_CNT_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // Fallbacks and floors; the noise scale of four is a shift by two bits
    localparam logic signed [POS_W-1:0] FALLBACK_POSITION  = 18'sd20000;
    localparam logic [PSPREAD_W+1:0]    MIN_POSITION_NOISE = 19'd5000;
    localparam logic [LSPREAD_W+1:0]    MIN_LOAD_MARGIN    = 17'd40;

    typedef enum logic [1:0] {
        VERDICT_INCONCLUSIVE = 2'd0,
        VERDICT_HOLDING      = 2'd1,
        VERDICT_EMPTY        = 2'd2
    } verdict_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASELINE_VALID    = 3'd0,
        CFG_BASELINE_POSITION = 3'd1,
        CFG_POSITION_SPREAD   = 3'd2,
        CFG_LOAD_BASELINE     = 3'd3,
        CFG_LOAD_SPREAD       = 3'd4,
        CFG_OPENING_MARGIN    = 3'd5,
        CFG_MINIMUM_LOAD      = 3'd6,
        CFG_REQUIRED_RUN      = 3'd7
    } cfg_index_t;

    // Control for one run counter, per sample
    typedef struct packed {
        logic advance;
        logic clear;
        logic sample_ok;
        logic evidence;
    } run_ctl_t;

endpackage

`default_nettype wire

>>> design/ghrc_run_counter.sv
// Saturating consecutive-run counter with its running maximum.
`default_nettype none

module ghrc_run_counter #(
    parameter int COUNTER_WIDTH = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire ghrc_pkg::run_ctl_t                  ctl,
    output logic [COUNTER_WIDTH-1:0]                 run_now,
    output logic [ghrc_pkg::OUT_CNT_W-1:0]           max_view
);

    logic [COUNTER_WIDTH-1:0] run_reg;
    logic [COUNTER_WIDTH-1:0] max_reg;
    logic [COUNTER_WIDTH-1:0] run_base;
    logic [COUNTER_WIDTH-1:0] run_inc;
    logic [COUNTER_WIDTH-1:0] max_base;
    logic [COUNTER_WIDTH-1:0] max_next;

    always_comb
    begin
        run_base = ctl.clear ? '0 : run_reg;
        max_base = ctl.clear ? '0 : max_reg;
        // hold at all ones
        run_inc  = (run_base == '1) ? run_base : run_base + 1'b1;
        run_now  = (ctl.sample_ok && ctl.evidence) ? run_inc : '0;
        max_next = (run_now > max_base) ? run_now : max_base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= '0;
            max_reg <= '0;
        end
        else if (ctl.advance)
        begin
            run_reg <= run_now;
            max_reg <= max_next;
        end
    end

    generate
        if (COUNTER_WIDTH >= ghrc_pkg::OUT_CNT_W)
        begin : g_trunc
            assign max_view = max_next[ghrc_pkg::OUT_CNT_W-1:0];
        end
        else
        begin : g_extend
            assign max_view = {{(ghrc_pkg::OUT_CNT_W-COUNTER_WIDTH){1'b0}}, max_next};
        end
    endgenerate

endmodule

`default_nettype wire

>>> design/grip_holding_run_classifier.sv
// Grip holding run classifier: top level with thresholds, runs and result register.
`default_nettype none

// Each accepted sample gives exactly one result: the sample is held in the input
// register, then the threshold compares and run updates are written into the result
// register, which waits while the result side is stalled. A new sample may be
// taken every cycle while item_stall is low; the run counters, held in flip-flops and
// updated from the input register stage, are the only loop. Thresholds are
// derived from the configuration registers, written through the configuration
// port (always ready); the user must write them only while no sample is in flight,
// which the block itself does not enforce. Run and sample counters are
// COUNTER_WIDTH bits wide and saturate; result fields carry their low 16 bits.

module grip_holding_run_classifier #(
    parameter int COUNTER_WIDTH = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    // configuration write channel
    input  wire logic                                     cfg_valid,
    output logic                                          cfg_ready,
    input  wire logic [ghrc_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  wire logic [ghrc_pkg::CFG_DATA_W-1:0]          cfg_data,
    // sample channel
    input  wire logic                                     item_valid,
    output logic                                          item_stall,
    input  wire logic                                     start_window,
    input  wire logic                                     sample_valid,
    input  wire logic signed [ghrc_pkg::POS_W-1:0]        position,
    input  wire logic signed [ghrc_pkg::LOAD_W-1:0]       load,
    input  wire logic                                     holding_flag,
    input  wire logic                                     empty_flag,
    // result channel
    output logic                                          result_valid,
    input  wire logic                                     result_stall,
    output logic [1:0]                                    verdict,
    output logic signed [ghrc_pkg::OBJ_THR_W-1:0]         object_position_threshold,
    output logic signed [ghrc_pkg::LOAD_THR_W-1:0]        load_threshold,
    output logic [ghrc_pkg::OUT_CNT_W-1:0]                valid_samples,
    output logic signed [ghrc_pkg::POS_W-1:0]             last_position,
    output logic signed [ghrc_pkg::LOAD_W-1:0]            last_load,
    output logic [ghrc_pkg::OUT_CNT_W-1:0]                opening_run_max,
    output logic [ghrc_pkg::OUT_CNT_W-1:0]                load_run_max,
    output logic [ghrc_pkg::OUT_CNT_W-1:0]                holding_flag_run_max,
    output logic [ghrc_pkg::OUT_CNT_W-1:0]                contact_run_max,
    output logic [ghrc_pkg::OUT_CNT_W-1:0]                empty_run_max
);

    localparam int CMP_W = (COUNTER_WIDTH > ghrc_pkg::REQ_W) ? COUNTER_WIDTH
                                                              : ghrc_pkg::REQ_W;

    // ---------------------------------------------------------------- config
    logic                                       baseline_valid_reg;
    logic signed [ghrc_pkg::POS_W-1:0]          baseline_position_reg;
    logic [ghrc_pkg::PSPREAD_W-1:0]             position_spread_reg;
    logic signed [ghrc_pkg::LOAD_W-1:0]         load_baseline_reg;
    logic [ghrc_pkg::LSPREAD_W-1:0]             load_spread_reg;
    logic signed [ghrc_pkg::POS_W-1:0]          opening_margin_reg;
    logic signed [ghrc_pkg::LOAD_W-1:0]         minimum_load_reg;
    logic [ghrc_pkg::REQ_W-1:0]                 required_run_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_valid_reg    <= 1'b0;
            baseline_position_reg <= '0;
            position_spread_reg   <= '0;
            load_baseline_reg     <= '0;
            load_spread_reg       <= '0;
            opening_margin_reg    <= '0;
            minimum_load_reg      <= '0;
            required_run_reg      <= 16'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (ghrc_pkg::cfg_index_t'(cfg_index))
                ghrc_pkg::CFG_BASELINE_VALID:
                    baseline_valid_reg <= cfg_data[0];
                ghrc_pkg::CFG_BASELINE_POSITION:
                    baseline_position_reg <= cfg_data[ghrc_pkg::POS_W-1:0];
                ghrc_pkg::CFG_POSITION_SPREAD:
                    position_spread_reg <= cfg_data[ghrc_pkg::PSPREAD_W-1:0];
                ghrc_pkg::CFG_LOAD_BASELINE:
                    load_baseline_reg <= cfg_data[ghrc_pkg::LOAD_W-1:0];
                ghrc_pkg::CFG_LOAD_SPREAD:
                    load_spread_reg <= cfg_data[ghrc_pkg::LSPREAD_W-1:0];
                ghrc_pkg::CFG_OPENING_MARGIN:
                    opening_margin_reg <= cfg_data[ghrc_pkg::POS_W-1:0];
                ghrc_pkg::CFG_MINIMUM_LOAD:
                    minimum_load_reg <= cfg_data[ghrc_pkg::LOAD_W-1:0];
                ghrc_pkg::CFG_REQUIRED_RUN:
                    required_run_reg <= cfg_data[ghrc_pkg::REQ_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // ------------------------------------------------------------ handshake
    logic s1_valid_reg;
    logic s1_valid_next;
    logic result_valid_reg;
    logic result_valid_next;
    logic out_free;
    logic advance;
    logic take_item;

    assign out_free   = !result_valid_reg || !result_stall;
    assign advance    = s1_valid_reg && out_free;
    assign item_stall = s1_valid_reg && !out_free;
    assign take_item  = item_valid && !item_stall;

    always_comb
    begin
        if (take_item)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (advance)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;

    // ------------------------------------------------------- input register
    logic                                   s1_start_reg;
    logic                                   s1_ok_reg;
    logic signed [ghrc_pkg::POS_W-1:0]      s1_pos_reg;
    logic signed [ghrc_pkg::LOAD_W-1:0]     s1_load_reg;
    logic                                   s1_hflag_reg;
    logic                                   s1_eflag_reg;

    always_ff @(posedge clk)
    begin
        if (take_item)
        begin
            s1_start_reg <= start_window;
            s1_ok_reg    <= sample_valid;
            s1_pos_reg   <= position;
            s1_load_reg  <= load;
            s1_hflag_reg <= holding_flag;
            s1_eflag_reg <= empty_flag;
        end
    end

    // ----------------------------------------------------------- thresholds
    logic signed [ghrc_pkg::POS_W-1:0]       base_pos;
    logic [ghrc_pkg::PSPREAD_W+1:0]          pos_scaled;
    logic [ghrc_pkg::PSPREAD_W+1:0]          noise;
    logic signed [19:0]                      noise_s;
    logic signed [19:0]                      margin_s;
    logic signed [19:0]                      gap;
    logic signed [ghrc_pkg::OBJ_THR_W-1:0]   obj_thr;
    logic signed [23:0]                      noise2_s;
    logic signed [23:0]                      margin_pos_s;
    logic signed [23:0]                      part_gap;
    logic signed [23:0]                      part_thr2;
    logic [ghrc_pkg::LSPREAD_W+1:0]          load_scaled;
    logic [ghrc_pkg::LSPREAD_W+1:0]          load_margin;
    logic signed [ghrc_pkg::LOAD_THR_W-1:0]  load_sum;
    logic signed [ghrc_pkg::LOAD_THR_W-1:0]  min_load_s;
    logic signed [ghrc_pkg::LOAD_THR_W-1:0]  load_pick;
    logic signed [ghrc_pkg::LOAD_THR_W-1:0]  load_thr;

    always_comb
    begin
        base_pos   = baseline_valid_reg ? baseline_position_reg
                                        : ghrc_pkg::FALLBACK_POSITION;
        pos_scaled = {position_spread_reg, 2'b00};
        if (baseline_valid_reg && (pos_scaled > ghrc_pkg::MIN_POSITION_NOISE))
            noise = pos_scaled;
        else
            noise = ghrc_pkg::MIN_POSITION_NOISE;
        noise_s  = {1'b0, noise};
        margin_s = {{2{opening_margin_reg[ghrc_pkg::POS_W-1]}}, opening_margin_reg};
        gap      = (margin_s > noise_s) ? margin_s : noise_s;
        obj_thr  = {{3{base_pos[ghrc_pkg::POS_W-1]}}, base_pos} + {gap[19], gap};

        // partial opening compared at twice scale so the half margin stays exact
        noise2_s     = {4'b0000, noise, 1'b0};
        margin_pos_s = opening_margin_reg[ghrc_pkg::POS_W-1] ? 24'sd0
                     : {6'b000000, opening_margin_reg};
        part_gap     = (margin_pos_s > noise2_s) ? margin_pos_s : noise2_s;
        part_thr2    = {{5{base_pos[ghrc_pkg::POS_W-1]}}, base_pos, 1'b0} + part_gap;

        load_scaled = {load_spread_reg, 2'b00};
        load_margin = (load_scaled > ghrc_pkg::MIN_LOAD_MARGIN) ? load_scaled
                                                                : ghrc_pkg::MIN_LOAD_MARGIN;
        load_sum    = {{3{load_baseline_reg[ghrc_pkg::LOAD_W-1]}}, load_baseline_reg}
                    + {2'b00, load_margin};
        min_load_s  = {{3{minimum_load_reg[ghrc_pkg::LOAD_W-1]}}, minimum_load_reg};
        load_pick   = baseline_valid_reg ? load_sum : min_load_s;
        load_thr    = (load_pick > min_load_s) ? load_pick : min_load_s;
    end

    // -------------------------------------------------------------- evidence
    logic signed [ghrc_pkg::OBJ_THR_W-1:0]   pos_wide;
    logic signed [23:0]                      pos2;
    logic signed [ghrc_pkg::LOAD_THR_W-1:0]  load_wide;
    logic                                    ev_opening;
    logic                                    ev_partial;
    logic                                    ev_loaded;
    logic                                    ev_contact;
    logic                                    ev_empty;

    always_comb
    begin
        pos_wide   = {{3{s1_pos_reg[ghrc_pkg::POS_W-1]}}, s1_pos_reg};
        pos2       = {{5{s1_pos_reg[ghrc_pkg::POS_W-1]}}, s1_pos_reg, 1'b0};
        load_wide  = {{3{s1_load_reg[ghrc_pkg::LOAD_W-1]}}, s1_load_reg};
        ev_opening = pos_wide > obj_thr;
        ev_partial = pos2 > part_thr2;
        ev_loaded  = load_wide >= load_thr;
        // two of three votes, or load with a partial opening
        ev_contact = (ev_opening && ev_loaded) || (ev_opening && s1_hflag_reg)
                   || (ev_loaded && s1_hflag_reg) || (ev_loaded && ev_partial);
        ev_empty   = !ev_opening && !ev_loaded && s1_eflag_reg;
    end

    // ---------------------------------------------------------- run counters
    ghrc_pkg::run_ctl_t                  ctl_opening;
    ghrc_pkg::run_ctl_t                  ctl_loaded;
    ghrc_pkg::run_ctl_t                  ctl_holding;
    ghrc_pkg::run_ctl_t                  ctl_contact;
    ghrc_pkg::run_ctl_t                  ctl_empty;
    logic [COUNTER_WIDTH-1:0]            opening_run_now;
    logic [COUNTER_WIDTH-1:0]            load_run_now;
    logic [COUNTER_WIDTH-1:0]            holding_run_now;
    logic [COUNTER_WIDTH-1:0]            contact_run_now;
    logic [COUNTER_WIDTH-1:0]            empty_run_now;
    logic [ghrc_pkg::OUT_CNT_W-1:0]      opening_max_view;
    logic [ghrc_pkg::OUT_CNT_W-1:0]      load_max_view;
    logic [ghrc_pkg::OUT_CNT_W-1:0]      holding_max_view;
    logic [ghrc_pkg::OUT_CNT_W-1:0]      contact_max_view;
    logic [ghrc_pkg::OUT_CNT_W-1:0]      empty_max_view;

    assign ctl_opening = '{advance: advance, clear: s1_start_reg,
                           sample_ok: s1_ok_reg, evidence: ev_opening};
    assign ctl_loaded  = '{advance: advance, clear: s1_start_reg,
                           sample_ok: s1_ok_reg, evidence: ev_loaded};
    assign ctl_holding = '{advance: advance, clear: s1_start_reg,
                           sample_ok: s1_ok_reg, evidence: s1_hflag_reg};
    assign ctl_contact = '{advance: advance, clear: s1_start_reg,
                           sample_ok: s1_ok_reg, evidence: ev_contact};
    assign ctl_empty   = '{advance: advance, clear: s1_start_reg,
                           sample_ok: s1_ok_reg, evidence: ev_empty};

    ghrc_run_counter #(.COUNTER_WIDTH(COUNTER_WIDTH)) u_opening_run (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_opening),
        .run_now  (opening_run_now),
        .max_view (opening_max_view)
    );

    ghrc_run_counter #(.COUNTER_WIDTH(COUNTER_WIDTH)) u_load_run (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_loaded),
        .run_now  (load_run_now),
        .max_view (load_max_view)
    );

    ghrc_run_counter #(.COUNTER_WIDTH(COUNTER_WIDTH)) u_holding_run (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_holding),
        .run_now  (holding_run_now),
        .max_view (holding_max_view)
    );

    ghrc_run_counter #(.COUNTER_WIDTH(COUNTER_WIDTH)) u_contact_run (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_contact),
        .run_now  (contact_run_now),
        .max_view (contact_max_view)
    );

    ghrc_run_counter #(.COUNTER_WIDTH(COUNTER_WIDTH)) u_empty_run (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_empty),
        .run_now  (empty_run_now),
        .max_view (empty_max_view)
    );

    // ------------------------------------------------- sample count and hold
    logic [COUNTER_WIDTH-1:0]            total_reg;
    logic [COUNTER_WIDTH-1:0]            total_base;
    logic [COUNTER_WIDTH-1:0]            total_next;
    logic [ghrc_pkg::OUT_CNT_W-1:0]      total_view;
    logic signed [ghrc_pkg::POS_W-1:0]   held_position_reg;
    logic signed [ghrc_pkg::LOAD_W-1:0]  held_load_reg;
    logic signed [ghrc_pkg::POS_W-1:0]   held_position_next;
    logic signed [ghrc_pkg::LOAD_W-1:0]  held_load_next;

    always_comb
    begin
        total_base = s1_start_reg ? '0 : total_reg;
        if (!s1_ok_reg)
            total_next = total_base;
        else if (total_base == '1)
            total_next = total_base;
        else
            total_next = total_base + 1'b1;
        held_position_next = s1_ok_reg ? s1_pos_reg : held_position_reg;
        held_load_next     = s1_ok_reg ? s1_load_reg : held_load_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg         <= '0;
            held_position_reg <= '0;
            held_load_reg     <= '0;
        end
        else if (advance)
        begin
            total_reg         <= total_next;
            held_position_reg <= held_position_next;
            held_load_reg     <= held_load_next;
        end
    end

    generate
        if (COUNTER_WIDTH >= ghrc_pkg::OUT_CNT_W)
        begin : g_total_trunc
            assign total_view = total_next[ghrc_pkg::OUT_CNT_W-1:0];
        end
        else
        begin : g_total_extend
            assign total_view = {{(ghrc_pkg::OUT_CNT_W-COUNTER_WIDTH){1'b0}}, total_next};
        end
    endgenerate

    // --------------------------------------------------------------- verdict
    logic [ghrc_pkg::REQ_W-1:0]  req_eff;
    logic [CMP_W-1:0]            req_cmp;
    logic [CMP_W-1:0]            contact_cmp;
    logic [CMP_W-1:0]            empty_cmp;
    ghrc_pkg::verdict_t          verdict_next;

    always_comb
    begin
        req_eff     = (required_run_reg == '0) ? 16'd1 : required_run_reg;
        req_cmp     = CMP_W'(req_eff);
        contact_cmp = CMP_W'(contact_run_now);
        empty_cmp   = CMP_W'(empty_run_now);
        // holding takes priority over empty
        if (contact_cmp >= req_cmp)
            verdict_next = ghrc_pkg::VERDICT_HOLDING;
        else if (empty_cmp >= req_cmp)
            verdict_next = ghrc_pkg::VERDICT_EMPTY;
        else
            verdict_next = ghrc_pkg::VERDICT_INCONCLUSIVE;
    end

    // ------------------------------------------------------- result register
    ghrc_pkg::verdict_t                      verdict_reg;
    logic signed [ghrc_pkg::OBJ_THR_W-1:0]   obj_thr_reg;
    logic signed [ghrc_pkg::LOAD_THR_W-1:0]  load_thr_reg;
    logic [ghrc_pkg::OUT_CNT_W-1:0]          valid_samples_reg;
    logic signed [ghrc_pkg::POS_W-1:0]       last_position_reg;
    logic signed [ghrc_pkg::LOAD_W-1:0]      last_load_reg;
    logic [ghrc_pkg::OUT_CNT_W-1:0]          opening_max_reg;
    logic [ghrc_pkg::OUT_CNT_W-1:0]          load_max_reg;
    logic [ghrc_pkg::OUT_CNT_W-1:0]          holding_max_reg;
    logic [ghrc_pkg::OUT_CNT_W-1:0]          contact_max_reg;
    logic [ghrc_pkg::OUT_CNT_W-1:0]          empty_max_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            verdict_reg       <= verdict_next;
            obj_thr_reg       <= obj_thr;
            load_thr_reg      <= load_thr;
            valid_samples_reg <= total_view;
            last_position_reg <= held_position_next;
            last_load_reg     <= held_load_next;
            opening_max_reg   <= opening_max_view;
            load_max_reg      <= load_max_view;
            holding_max_reg   <= holding_max_view;
            contact_max_reg   <= contact_max_view;
            empty_max_reg     <= empty_max_view;
        end
    end

    assign verdict                   = verdict_reg;
    assign object_position_threshold = obj_thr_reg;
    assign load_threshold            = load_thr_reg;
    assign valid_samples             = valid_samples_reg;
    assign last_position             = last_position_reg;
    assign last_load                 = last_load_reg;
    assign opening_run_max           = opening_max_reg;
    assign load_run_max              = load_max_reg;
    assign holding_flag_run_max      = holding_max_reg;
    assign contact_run_max           = contact_max_reg;
    assign empty_run_max             = empty_max_reg;

endmodule

`default_nettype wire

>>> tb/ghrc_result_check.sv
// Result checker for the grip holding run classifier: predicts each verdict record and compares.

module ghrc_result_check
    import ghrc_pkg::*;
#(
    parameter int CW = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          item_valid,
    input  logic                          item_stall,
    input  logic                          start_window,
    input  logic                          sample_valid,
    input  logic signed [POS_W-1:0]       position,
    input  logic signed [LOAD_W-1:0]      load,
    input  logic                          holding_flag,
    input  logic                          empty_flag,
    input  logic                          result_valid,
    input  logic                          result_stall,
    input  logic [1:0]                    verdict,
    input  logic signed [OBJ_THR_W-1:0]   object_position_threshold,
    input  logic signed [LOAD_THR_W-1:0]  load_threshold,
    input  logic [OUT_CNT_W-1:0]          valid_samples,
    input  logic signed [POS_W-1:0]       last_position,
    input  logic signed [LOAD_W-1:0]      last_load,
    input  logic [OUT_CNT_W-1:0]          opening_run_max,
    input  logic [OUT_CNT_W-1:0]          load_run_max,
    input  logic [OUT_CNT_W-1:0]          holding_flag_run_max,
    input  logic [OUT_CNT_W-1:0]          contact_run_max,
    input  logic [OUT_CNT_W-1:0]          empty_run_max,
    output int                            mismatches,
    output int                            awaited,
    output int                            checked
);

    localparam longint FALLBACK_UM       = 20000;
    localparam longint NOISE_FLOOR_UM    = 5000;
    localparam longint LOAD_MARGIN_FLOOR = 40;
    localparam longint SPREAD_GAIN       = 4;

    // evidence order, also the order of the maxima in the record
    localparam int EV_OPENING = 0;
    localparam int EV_LOADED  = 1;
    localparam int EV_HOLDING = 2;
    localparam int EV_CONTACT = 3;
    localparam int EV_EMPTY   = 4;

    typedef struct packed {
        verdict_t                        verdict;
        logic signed [OBJ_THR_W-1:0]     obj_thr;
        logic signed [LOAD_THR_W-1:0]    load_thr;
        logic [OUT_CNT_W-1:0]            count;
        logic signed [POS_W-1:0]         last_pos;
        logic signed [LOAD_W-1:0]        last_load;
        logic [4:0][OUT_CNT_W-1:0]       peaks;
    } grip_report_t;

    // register copy
    logic                       bl_valid;
    logic signed [POS_W-1:0]    bl_pos;
    logic [PSPREAD_W-1:0]       pos_spread;
    logic signed [LOAD_W-1:0]   bl_load;
    logic [LSPREAD_W-1:0]       ld_spread;
    logic signed [POS_W-1:0]    open_margin;
    logic signed [LOAD_W-1:0]   load_floor;
    logic [REQ_W-1:0]           run_needed;

    // run state
    logic [CW-1:0]              run_len [5];
    logic [CW-1:0]              run_peak [5];
    logic [CW-1:0]              good_count;
    logic signed [POS_W-1:0]    kept_pos;
    logic signed [LOAD_W-1:0]   kept_load;

    grip_report_t owed_reports[$];

    string peak_names [5] = '{"opening_run_max", "load_run_max", "holding_flag_run_max",
                              "contact_run_max", "empty_run_max"};

    function automatic longint larger(input longint a, input longint b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [CW-1:0] bump(input logic hit, input logic [CW-1:0] n);
        if (!hit)
            return '0;
        return (n == {CW{1'b1}}) ? n : n + 1'b1;
    endfunction

    function automatic grip_report_t classify_sample(input logic clear, input logic ok,
                                                     input logic signed [POS_W-1:0] pos,
                                                     input logic signed [LOAD_W-1:0] ld,
                                                     input logic hflag, input logic eflag);
        longint       base, noise, obj_thr, half_thr2, ld_thr, need;
        logic         opening, partial, loaded, contact, emptyish;
        logic [4:0]   hits;
        grip_report_t r;
        base  = bl_valid ? longint'(bl_pos) : FALLBACK_UM;
        noise = bl_valid ? larger(NOISE_FLOOR_UM, SPREAD_GAIN * longint'(pos_spread))
                         : NOISE_FLOOR_UM;
        obj_thr   = base + larger(longint'(open_margin), noise);
        // doubled so that an odd margin halves exactly
        half_thr2 = 2 * base + larger(2 * noise, larger(0, longint'(open_margin)));
        ld_thr = bl_valid ? longint'(bl_load)
                            + larger(LOAD_MARGIN_FLOOR, SPREAD_GAIN * longint'(ld_spread))
                          : longint'(load_floor);
        ld_thr = larger(longint'(load_floor), ld_thr);
        need   = (run_needed == '0) ? 1 : longint'(run_needed);

        if (clear)
        begin
            for (int i = 0; i < 5; i++)
            begin
                run_len[i]  = '0;
                run_peak[i] = '0;
            end
            good_count = '0;
        end

        if (!ok)
        begin
            for (int i = 0; i < 5; i++)
                run_len[i] = '0;
        end
        else
        begin
            opening  = longint'(pos) > obj_thr;
            partial  = 2 * longint'(pos) > half_thr2;
            loaded   = longint'(ld) >= ld_thr;
            contact  = (int'(opening) + int'(loaded) + int'(hflag) >= 2) || (loaded && partial);
            emptyish = !opening && !loaded && eflag;
            hits     = {emptyish, contact, hflag, loaded, opening};
            good_count = bump(1'b1, good_count);
            kept_pos   = pos;
            kept_load  = ld;
            for (int i = 0; i < 5; i++)
            begin
                run_len[i] = bump(hits[i], run_len[i]);
                if (run_len[i] > run_peak[i])
                    run_peak[i] = run_len[i];
            end
        end

        if (longint'(run_len[EV_CONTACT]) >= need)
            r.verdict = VERDICT_HOLDING;
        else if (longint'(run_len[EV_EMPTY]) >= need)
            r.verdict = VERDICT_EMPTY;
        else
            r.verdict = VERDICT_INCONCLUSIVE;
        r.obj_thr   = obj_thr[OBJ_THR_W-1:0];
        r.load_thr  = ld_thr[LOAD_THR_W-1:0];
        r.count     = OUT_CNT_W'(good_count);
        r.last_pos  = kept_pos;
        r.last_load = kept_load;
        for (int i = 0; i < 5; i++)
            r.peaks[i] = OUT_CNT_W'(run_peak[i]);
        return r;
    endfunction

    task automatic note(input string what, input longint want, input longint got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    task automatic compare_report(input grip_report_t want, input grip_report_t seen);
        note("verdict", want.verdict, seen.verdict);
        note("object_position_threshold", want.obj_thr, seen.obj_thr);
        note("load_threshold", want.load_thr, seen.load_thr);
        note("valid_samples", want.count, seen.count);
        note("last_position", want.last_pos, seen.last_pos);
        note("last_load", want.last_load, seen.last_load);
        for (int i = 0; i < 5; i++)
            note(peak_names[i], want.peaks[i], seen.peaks[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        grip_report_t seen;
        logic         took, gave;
        if (!rst_n)
        begin
            bl_valid    = 1'b0;
            bl_pos      = '0;
            pos_spread  = '0;
            bl_load     = '0;
            ld_spread   = '0;
            open_margin = '0;
            load_floor  = '0;
            run_needed  = REQ_W'(1);
            for (int i = 0; i < 5; i++)
            begin
                run_len[i]  = '0;
                run_peak[i] = '0;
            end
            good_count = '0;
            kept_pos   = '0;
            kept_load  = '0;
            owed_reports.delete();
            mismatches = 0;
            checked    = 0;
            awaited   <= 0;
        end
        else
        begin
            gave = result_valid && !result_stall;
            took = item_valid && !item_stall;
            if (gave)
            begin
                seen.verdict   = verdict_t'(verdict);
                seen.obj_thr   = object_position_threshold;
                seen.load_thr  = load_threshold;
                seen.count     = valid_samples;
                seen.last_pos  = last_position;
                seen.last_load = last_load;
                seen.peaks     = {empty_run_max, contact_run_max, holding_flag_run_max,
                                  load_run_max, opening_run_max};
                checked++;
                if (owed_reports.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result transfer with nothing owed: %s %0d",
                             $time, "expected none, got verdict", verdict);
                end
                else
                    compare_report(owed_reports.pop_front(), seen);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_BASELINE_VALID:    bl_valid    = cfg_data[0];
                    CFG_BASELINE_POSITION: bl_pos      = cfg_data[POS_W-1:0];
                    CFG_POSITION_SPREAD:   pos_spread  = cfg_data[PSPREAD_W-1:0];
                    CFG_LOAD_BASELINE:     bl_load     = cfg_data[LOAD_W-1:0];
                    CFG_LOAD_SPREAD:       ld_spread   = cfg_data[LSPREAD_W-1:0];
                    CFG_OPENING_MARGIN:    open_margin = cfg_data[POS_W-1:0];
                    CFG_MINIMUM_LOAD:      load_floor  = cfg_data[LOAD_W-1:0];
                    CFG_REQUIRED_RUN:      run_needed  = cfg_data[REQ_W-1:0];
                    default: ;
                endcase
            end
            if (took)
                owed_reports.insert(owed_reports.size(),
                                    classify_sample(start_window, sample_valid, position,
                                                    load, holding_flag, empty_flag));
            awaited <= awaited + int'(took) - int'(gave && awaited > 0);
        end
    end

endmodule

>>> tb/grip_holding_run_classifier_test.sv
// Testbench top for the grip holding run classifier: stimulus, handshake pacing and verdict.

module grip_holding_run_classifier_test;
    import ghrc_pkg::*;

    localparam int CW          = 16;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int BURST_LEN   = 24;
    localparam int POS_LO      = -100000;
    localparam int POS_HI      = 100000;
    localparam int LD_LO       = -32768;
    localparam int LD_HI       = 32767;

    typedef struct {
        int valid_flag;
        int base_pos;
        int pos_dev;
        int base_load;
        int load_dev;
        int margin;
        int load_min;
        int run_req;
    } grip_setup_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    cfg_index_t                   cfg_index = CFG_BASELINE_VALID;
    logic [CFG_DATA_W-1:0]        cfg_data = '0;
    logic                         item_valid = 1'b0;
    logic                         item_stall;
    logic                         start_window = 1'b0;
    logic                         sample_valid = 1'b0;
    logic signed [POS_W-1:0]      position = '0;
    logic signed [LOAD_W-1:0]     load = '0;
    logic                         holding_flag = 1'b0;
    logic                         empty_flag = 1'b0;
    logic                         result_valid;
    logic                         result_stall = 1'b0;
    logic [1:0]                   verdict;
    logic signed [OBJ_THR_W-1:0]  object_position_threshold;
    logic signed [LOAD_THR_W-1:0] load_threshold;
    logic [OUT_CNT_W-1:0]         valid_samples;
    logic signed [POS_W-1:0]      last_position;
    logic signed [LOAD_W-1:0]     last_load;
    logic [OUT_CNT_W-1:0]         opening_run_max;
    logic [OUT_CNT_W-1:0]         load_run_max;
    logic [OUT_CNT_W-1:0]         holding_flag_run_max;
    logic [OUT_CNT_W-1:0]         contact_run_max;
    logic [OUT_CNT_W-1:0]         empty_run_max;

    int mismatches;
    int awaited;
    int checked;

    int cycles = 0;
    int sent = 0;
    int setups = 0;
    int hold_off = 0;
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int pos_pivot, half_pivot, load_pivot;

    always #2 clk = ~clk;

    grip_holding_run_classifier #(.COUNTER_WIDTH(CW)) u_top (.*);

    ghrc_result_check #(.CW(CW)) u_check (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    function automatic int clip(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int jitter(input int centre, input int span, input int lo, input int hi);
        return clip(centre + int'($urandom_range(0, 2 * span)) - span, lo, hi);
    endfunction

    function automatic int pace();
        return tx_steady ? 0 : int'($urandom_range(0, 9));
    endfunction

    // aim points near the thresholds so that random samples straddle them
    function automatic void aim(input grip_setup_t s);
        int base, noise;
        base       = s.valid_flag ? s.base_pos : 20000;
        noise      = s.valid_flag ? imax(5000, 4 * s.pos_dev) : 5000;
        pos_pivot  = base + imax(s.margin, noise);
        half_pivot = base + imax(noise, imax(0, s.margin) / 2);
        load_pivot = s.valid_flag ? imax(s.load_min, s.base_load + imax(40, 4 * s.load_dev))
                                  : s.load_min;
    endfunction

    task automatic put_reg(input cfg_index_t idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic apply_setup(input grip_setup_t s);
        put_reg(CFG_BASELINE_VALID, s.valid_flag);
        put_reg(CFG_BASELINE_POSITION, s.base_pos);
        put_reg(CFG_POSITION_SPREAD, s.pos_dev);
        put_reg(CFG_LOAD_BASELINE, s.base_load);
        put_reg(CFG_LOAD_SPREAD, s.load_dev);
        put_reg(CFG_OPENING_MARGIN, s.margin);
        put_reg(CFG_MINIMUM_LOAD, s.load_min);
        put_reg(CFG_REQUIRED_RUN, s.run_req);
        cfg_valid <= 1'b0;
        aim(s);
        setups++;
    endtask

    task automatic offer(input logic clear, input logic ok, input int pos, input int ld,
                         input logic hf, input logic ef, input int gap);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid   <= 1'b1;
        start_window <= clear;
        sample_valid <= ok;
        position     <= POS_W'(pos);
        load         <= LOAD_W'(ld);
        holding_flag <= hf;
        empty_flag   <= ef;
        do @(posedge clk); while (item_stall);
        sent++;
    endtask

    // drop valid and let every owed result come back
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (awaited != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic burst(input logic grip);
        for (int k = 0; k < BURST_LEN; k++)
        begin
            if (grip)
                offer(k == 0, 1'b1, POS_HI, LD_HI, 1'b1, 1'b0, 0);
            else
                offer(k == 0, 1'b1, POS_LO, LD_LO, 1'b0, 1'b1, 0);
        end
    endtask

    function automatic grip_setup_t rolled_setup();
        grip_setup_t s;
        s.valid_flag = ($urandom_range(0, 3) != 0);
        s.base_pos   = int'($urandom_range(0, 120000)) - 60000;
        s.pos_dev    = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 100000))
                                                   : int'($urandom_range(0, 8000));
        s.base_load  = int'($urandom_range(0, 40000)) - 20000;
        s.load_dev   = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 32767))
                                                   : int'($urandom_range(0, 3000));
        s.margin     = int'($urandom_range(0, 50000)) - 20000;
        s.load_min   = int'($urandom_range(0, 65535)) - 32768;
        s.run_req    = int'($urandom_range(0, 5));
        return s;
    endfunction

    // runs of grip-like or empty-like samples with random content, mixed with noise
    task automatic random_phase(input int count);
        int   left, kind, len, pos, ld;
        logic clear, ok, hf, ef;
        left = count;
        while (left > 0)
        begin
            kind = $urandom_range(0, 9);
            len  = $urandom_range(1, 12);
            for (int j = 0; j < len && left > 0; j++)
            begin
                clear = ($urandom_range(0, 39) == 0);
                ok    = ($urandom_range(0, 19) != 0);
                if (kind < 4)
                begin
                    case ($urandom_range(0, 2))
                        0:       pos = jitter(pos_pivot, 4, POS_LO, POS_HI);
                        1:       pos = jitter(half_pivot, 4, POS_LO, POS_HI);
                        default: pos = clip(pos_pivot + int'($urandom_range(0, 30000)),
                                            POS_LO, POS_HI);
                    endcase
                    ld = ($urandom_range(0, 3) == 0) ? jitter(load_pivot, 3, LD_LO, LD_HI)
                        : clip(load_pivot + int'($urandom_range(0, 20000)), LD_LO, LD_HI);
                    hf = ($urandom_range(0, 9) < 7);
                    ef = $urandom_range(0, 1);
                end
                else if (kind < 7)
                begin
                    pos = $urandom_range(0, 1) ? jitter(half_pivot, 4, POS_LO, POS_HI)
                        : clip(half_pivot - int'($urandom_range(1, 60000)), POS_LO, POS_HI);
                    ld = $urandom_range(0, 1) ? jitter(load_pivot, 3, LD_LO, LD_HI)
                        : clip(load_pivot - int'($urandom_range(1, 20000)), LD_LO, LD_HI);
                    hf = ($urandom_range(0, 4) == 0);
                    ef = ($urandom_range(0, 9) != 0);
                end
                else
                begin
                    pos = int'($urandom_range(0, 200000)) - 100000;
                    ld  = int'($urandom_range(0, 65535)) - 32768;
                    hf  = $urandom_range(0, 1);
                    ef  = $urandom_range(0, 1);
                end
                offer(clear, ok, pos, ld, hf, ef, pace());
                left--;
            end
        end
    endtask

    initial
    begin : result_side
        int n;
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_off > 0)
            begin
                n = hold_off;
                hold_off = 0;
            end
            else if (rx_steady)
                n = 0;
            else
                n = $urandom_range(0, 9);
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
        end
    end

    initial
    begin : stimulus
        grip_setup_t s;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: fallback thresholds, one-sample runs
        aim('{0, 0, 0, 0, 0, 0, 0, 1});
        offer(1'b0, 1'b1, POS_LO, LD_LO, 1'b0, 1'b1, pace());
        offer(1'b0, 1'b1, POS_HI, LD_HI, 1'b1, 1'b1, pace());
        offer(1'b0, 1'b1, 25000, 0, 1'b0, 1'b0, pace());
        offer(1'b0, 1'b1, 25001, -1, 1'b0, 1'b1, pace());
        offer(1'b0, 1'b0, POS_HI, LD_HI, 1'b1, 1'b0, pace());
        offer(1'b1, 1'b1, -5, -5, 1'b1, 1'b0, pace());
        offer(1'b1, 1'b0, 0, 0, 1'b0, 1'b0, pace());
        offer(1'b0, 1'b1, -1, -1, 1'b1, 1'b1, pace());
        offer(1'b0, 1'b1, 0, 1, 1'b1, 0, pace());
        drain();

        // odd margin above twice the noise floor, zero run length
        apply_setup('{1, 0, 0, LD_LO, 0, 12001, LD_LO, 0});
        offer(1'b0, 1'b1, 6000, -32728, 1'b0, 1'b0, pace());
        offer(1'b0, 1'b1, 6001, -32728, 1'b0, 1'b0, pace());
        offer(1'b0, 1'b1, 12001, -32729, 1'b0, 1'b1, pace());
        offer(1'b0, 1'b1, 12002, -32729, 1'b1, 1'b0, pace());
        offer(1'b0, 1'b1, POS_LO, LD_LO, 1'b0, 1'b1, pace());
        offer(1'b0, 1'b1, POS_LO, LD_LO, 1'b0, 1'b1, pace());
        drain();

        // steady grip and empty runs back to back, longest run length
        apply_setup('{0, 0, 0, 0, 0, 0, 0, 65535});
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        burst(1'b1);
        burst(1'b0);
        drain();
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        apply_setup('{1, POS_LO, 0, LD_LO, 0, POS_LO, LD_LO, 0});
        random_phase(180);
        drain();

        apply_setup('{1, POS_HI, 100000, LD_HI, 32767, POS_HI, LD_HI, 2});
        random_phase(100);
        drain();

        s = rolled_setup();
        s.valid_flag = 0;
        apply_setup(s);
        random_phase(60);
        // hold the result side while samples keep coming
        hold_off  = 300;
        tx_steady = 1'b1;
        random_phase(60);
        tx_steady = 1'b0;
        random_phase(60);
        drain();

        for (int p = 0; p < 4; p++)
        begin
            apply_setup(rolled_setup());
            tx_steady = (p == 2);
            rx_steady = (p == 2);
            random_phase(130);
            drain();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        repeat (8) @(posedge clk);

        $display("Checked %0d results from %0d samples under %0d register settings,",
                 checked, sent, setups);
        $display("with back-to-back grip and empty runs of %0d samples and a long hold-off.",
                 BURST_LEN);
        if (mismatches == 0 && awaited == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
